### rtl/core/rrss_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the round-robin slice scheduler.
// No dependencies; every other file of the block imports this package.
package rrss_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int BURST_W = 8;
    localparam int ID_W    = 16;
    localparam int TOTAL_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [BURST_W-1:0] QUANTUM_RST = 8'd6;
    localparam logic [TOTAL_W-1:0] BUDGET_RST  = 16'd16;
    localparam logic [ID_W-1:0]    FIRST_ID    = 16'd1;
    localparam logic [ID_W-1:0]    LAST_ID     = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic issue;   // capture the arrival, enqueue it and read the head entry
        logic commit;  // serve the slice and load the result register
    } rrss_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // the result register can take a new result this cycle
    } rrss_sts_t;

    function automatic logic [TOTAL_W-1:0] sat_add16(input logic [TOTAL_W-1:0] a,
                                                     input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    endfunction

endpackage

### rtl/core/rrss_ctrl.sv
`timescale 1ns / 1ps
// Two-state controller of the slice scheduler: issue an arrival, then commit it.
// Depends on rrss_pkg for the command and status structs.
module rrss_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rrss_pkg::rrss_sts_t sts,
    output rrss_pkg::rrss_cmd_t cmd
);
    import rrss_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.issue  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The result waits here until the output register has room.
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/rrss_datapath.sv
`timescale 1ns / 1ps
// Datapath of the slice scheduler: queue memory, indexes, totals, config and result register.
// Depends on rrss_pkg for widths, constants, command/status structs and sat_add16.
module rrss_datapath #(
    parameter int QUEUE_DEPTH = rrss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rrss_pkg::rrss_cmd_t               cmd,
    output rrss_pkg::rrss_sts_t               sts,
    input  logic                              cfg_write,
    input  logic [rrss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrss_pkg::CFG_W-1:0]        cfg_data,
    input  logic [rrss_pkg::BURST_W-1:0]      burst,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              accepted,
    output logic                              served,
    output logic [rrss_pkg::ID_W-1:0]         served_pid,
    output logic [rrss_pkg::BURST_W-1:0]      slice_length,
    output logic                              finished,
    output logic [rrss_pkg::TOTAL_W-1:0]      time_used,
    output logic [rrss_pkg::TOTAL_W-1:0]      time_saved,
    output logic [rrss_pkg::TOTAL_W-1:0]      slice_count,
    output logic                              halted
);
    import rrss_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    // Queue memory.
    logic [ID_W-1:0]    mem_id  [QUEUE_DEPTH];
    logic [BURST_W-1:0] mem_rem [QUEUE_DEPTH];

    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [ID_W-1:0]    next_id_reg, next_id_next;
    logic [TOTAL_W-1:0] used_reg, used_next;
    logic [TOTAL_W-1:0] saved_reg, saved_next;
    logic [TOTAL_W-1:0] slices_reg, slices_next;
    logic [BURST_W-1:0] quantum_reg;
    logic [TOTAL_W-1:0] budget_reg;
    logic               live_reg;
    logic               acc_reg;
    logic               byp_reg;
    logic               out_valid_reg, out_valid_next;

    logic [ID_W-1:0]    arr_id_reg;
    logic [BURST_W-1:0] arr_rem_reg;
    logic [ID_W-1:0]    rd_id_reg;
    logic [BURST_W-1:0] rd_rem_reg;

    logic               accepted_reg;
    logic               served_reg;
    logic [ID_W-1:0]    pid_reg;
    logic [BURST_W-1:0] slice_reg;
    logic               finished_reg;
    logic [TOTAL_W-1:0] used_out_reg;
    logic [TOTAL_W-1:0] saved_out_reg;
    logic [TOTAL_W-1:0] slices_out_reg;
    logic               halted_reg;

    logic               live;
    logic               acc;
    logic               serve;
    logic               rotate;
    logic [ID_W-1:0]    head_id;
    logic [BURST_W-1:0] head_rem;
    logic [BURST_W-1:0] slice;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ID_W-1:0]    wr_id;
    logic [BURST_W-1:0] wr_rem;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    assign live     = (used_reg <= budget_reg);
    assign acc      = live && (count_reg < FULL_CNT);
    // An arrival into an empty queue is itself the head; it bypasses the memory read.
    assign head_id  = byp_reg ? arr_id_reg  : rd_id_reg;
    assign head_rem = byp_reg ? arr_rem_reg : rd_rem_reg;
    assign serve    = live_reg && (count_reg != '0);
    assign rotate   = (head_rem > quantum_reg);
    assign slice    = rotate ? quantum_reg : head_rem;

    assign sts.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        next_id_next = next_id_reg;
        used_next    = used_reg;
        saved_next   = saved_reg;
        slices_next  = slices_reg;
        wr_en        = 1'b0;
        wr_addr      = tail_reg;
        wr_id        = next_id_reg;
        wr_rem       = burst;
        if (cmd.issue && acc)
        begin
            wr_en        = 1'b1;
            tail_next    = advance(tail_reg);
            count_next   = count_reg + CW'(1);
            next_id_next = (next_id_reg == LAST_ID) ? FIRST_ID : next_id_reg + ID_W'(1);
        end
        if (cmd.commit && serve)
        begin
            head_next   = advance(head_reg);
            used_next   = sat_add16(used_reg, TOTAL_W'(slice));
            slices_next = sat_add16(slices_reg, TOTAL_W'(1));
            if (rotate)
            begin
                wr_en     = 1'b1;
                wr_id     = head_id;
                wr_rem    = head_rem - quantum_reg;
                tail_next = advance(tail_reg);
            end
            else
            begin
                count_next = count_reg - CW'(1);
                saved_next = sat_add16(saved_reg, TOTAL_W'(quantum_reg - head_rem));
            end
        end
    end

    assign out_valid_next = cmd.commit ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_id[wr_addr]  <= wr_id;
            mem_rem[wr_addr] <= wr_rem;
        end
        if (cmd.issue)
        begin
            rd_id_reg   <= mem_id[head_reg];
            rd_rem_reg  <= mem_rem[head_reg];
            arr_id_reg  <= next_id_reg;
            arr_rem_reg <= burst;
        end
        if (cmd.commit)
        begin
            accepted_reg   <= acc_reg;
            served_reg     <= serve;
            pid_reg        <= serve ? head_id : '0;
            slice_reg      <= serve ? slice : '0;
            finished_reg   <= serve && !rotate;
            used_out_reg   <= used_next;
            saved_out_reg  <= saved_next;
            slices_out_reg <= slices_next;
            halted_reg     <= (used_next > budget_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            next_id_reg   <= FIRST_ID;
            used_reg      <= '0;
            saved_reg     <= '0;
            slices_reg    <= '0;
            quantum_reg   <= QUANTUM_RST;
            budget_reg    <= BUDGET_RST;
            live_reg      <= 1'b0;
            acc_reg       <= 1'b0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            used_reg      <= used_next;
            saved_reg     <= saved_next;
            slices_reg    <= slices_next;
            out_valid_reg <= out_valid_next;
            if (cmd.issue)
            begin
                live_reg <= live;
                acc_reg  <= acc;
                byp_reg  <= acc && (count_reg == '0);
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_QUANTUM: quantum_reg <= cfg_data[BURST_W-1:0];
                    CFG_BUDGET:  budget_reg  <= cfg_data[TOTAL_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign served       = served_reg;
    assign served_pid   = pid_reg;
    assign slice_length = slice_reg;
    assign finished     = finished_reg;
    assign time_used    = used_out_reg;
    assign time_saved   = saved_out_reg;
    assign slice_count  = slices_out_reg;
    assign halted       = halted_reg;

endmodule

### rtl/core/round_robin_slice_scheduler.sv
`timescale 1ns / 1ps
// Top level of the round-robin slice scheduler: controller plus datapath.
// Depends on rrss_pkg, rrss_ctrl and rrss_datapath.
//
//  Channel   Signals                                         Direction
//  -------   ---------------------------------------------   ---------
//  in        in_valid, in_stall, burst                       into block
//  out       out_valid, out_stall, accepted .. halted        out of block
//  cfg       cfg_write, cfg_index, cfg_data                  into block
//
// Each arrival is issued, which enqueues it and reads the head entry from the
// queue memory, then committed, which serves the slice and writes the rotated entry back.
// The single write port of the queue memory keeps these writes in separate states.
// Reset clears indexes and totals and sets the config registers to their defaults; the queue memory is not cleared.
// A stalled result holds in the output register; the next arrival is taken
// meanwhile and waits for commit only if the register is still full.
module round_robin_slice_scheduler #(
    parameter int QUEUE_DEPTH = rrss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rrss_pkg::BURST_W-1:0]      burst,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              accepted,
    output logic                              served,
    output logic [rrss_pkg::ID_W-1:0]         served_pid,
    output logic [rrss_pkg::BURST_W-1:0]      slice_length,
    output logic                              finished,
    output logic [rrss_pkg::TOTAL_W-1:0]      time_used,
    output logic [rrss_pkg::TOTAL_W-1:0]      time_saved,
    output logic [rrss_pkg::TOTAL_W-1:0]      slice_count,
    output logic                              halted,
    input  logic                              cfg_write,
    input  logic [rrss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrss_pkg::CFG_W-1:0]        cfg_data
);
    import rrss_pkg::*;

    rrss_cmd_t cmd;
    rrss_sts_t sts;

    rrss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrss_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .burst        (burst),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .served       (served),
        .served_pid   (served_pid),
        .slice_length (slice_length),
        .finished     (finished),
        .time_used    (time_used),
        .time_saved   (time_saved),
        .slice_count  (slice_count),
        .halted       (halted)
    );

endmodule

### rtl/core/rrss_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the slice scheduler, bound to the top level.
// Depends on rrss_pkg for field widths.
module rrss_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          served,
    input logic [rrss_pkg::ID_W-1:0]     served_pid,
    input logic [rrss_pkg::BURST_W-1:0]  slice_length,
    input logic                          finished,
    input logic [rrss_pkg::TOTAL_W-1:0]  time_used,
    input logic [rrss_pkg::TOTAL_W-1:0]  slice_count
);
    import rrss_pkg::*;

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(served_pid)
            && $stable(slice_length) && $stable(time_used))
        else $error("stalled result changed");

    // The block works on one arrival at a time.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction accepted while busy");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !served |-> served_pid == '0 && slice_length == '0 && !finished)
        else $error("unserved result carries slice data");

    a_pid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && served |-> served_pid != '0)
        else $error("served slice with process id zero");

    // Running totals never go backward.
    a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid) |->
            time_used >= $past(time_used) && slice_count >= $past(slice_count))
        else $error("running total decreased");

endmodule

bind round_robin_slice_scheduler rrss_checker u_rrss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .served       (served),
    .served_pid   (served_pid),
    .slice_length (slice_length),
    .finished     (finished),
    .time_used    (time_used),
    .slice_count  (slice_count)
);
